@@ rtl/marker_rle_decoder_top_assert.svh @@
// assertion macros shared by the marker rle decoder modules
// depends on a clock named clk and a synchronous active-high reset named rst in scope
`ifndef MARKER_RLE_DECODER_TOP_ASSERT_SVH
`define MARKER_RLE_DECODER_TOP_ASSERT_SVH

// antecedent holds, consequent holds in the same cycle
`define MRD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define MRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mrd_pkg.sv @@
// shared types and constants for the marker rle decoder
// no dependencies
package mrd_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] SHORT_DESC_MAX = 8'd2;

  typedef enum logic [2:0] {
    PH_AWAIT = 3'd0,
    PH_TOKEN = 3'd1,
    PH_DESC  = 3'd2,
    PH_LOW   = 3'd3,
    PH_VALUE = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0]  value;
    logic [15:0] count;
    logic        final_run;
    logic        truncated;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

@@ rtl/mrd_front.sv @@
// front end: accepts compressed bytes, tracks the token phase and forms runs
// depends on mrd_pkg and marker_rle_decoder_top_assert.svh
`include "marker_rle_decoder_top_assert.svh"

module mrd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic [7:0]    in_byte,
  input  logic          first_of_stream,
  input  logic          last_of_stream,
  output logic          emit,
  output mrd_pkg::run_t run
);
  import mrd_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  marker, marker_next;
  logic [14:0] run_count, run_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_AWAIT;
      marker    <= 8'd0;
      run_count <= 15'd0;
    end else if (in_fire) begin
      phase     <= phase_next;
      marker    <= marker_next;
      run_count <= run_count_next;
    end
  end

  // next state
  always_comb begin
    phase_next = phase;
    if (first_of_stream) begin
      phase_next = last_of_stream ? PH_AWAIT : PH_TOKEN;
    end else begin
      case (phase)
        PH_TOKEN: begin
          if (last_of_stream) phase_next = PH_AWAIT;
          else if (in_byte == marker) phase_next = PH_DESC;
        end
        PH_DESC: begin
          if (last_of_stream) phase_next = PH_AWAIT;
          else if (in_byte <= SHORT_DESC_MAX) phase_next = PH_TOKEN;
          else if (in_byte[7]) phase_next = PH_LOW;
          else phase_next = PH_VALUE;
        end
        PH_LOW: begin
          phase_next = last_of_stream ? PH_AWAIT : PH_VALUE;
        end
        PH_VALUE: begin
          phase_next = last_of_stream ? PH_AWAIT : PH_TOKEN;
        end
        default: begin
          phase_next = PH_AWAIT;
        end
      endcase
    end
  end

  // outputs and datapath
  always_comb begin
    marker_next    = marker;
    run_count_next = run_count;
    emit           = 1'b0;
    run            = '0;
    if (first_of_stream) begin
      marker_next    = in_byte;
      run_count_next = 15'd0;
      emit           = last_of_stream;
      run.final_run  = 1'b1;
    end else begin
      case (phase)
        PH_TOKEN: begin
          if (in_byte != marker) begin
            emit          = 1'b1;
            run.value     = in_byte;
            run.count     = 16'd1;
            run.final_run = last_of_stream;
          end else begin
            emit          = last_of_stream;
            run.final_run = 1'b1;
            run.truncated = 1'b1;
          end
        end
        PH_DESC: begin
          if (in_byte <= SHORT_DESC_MAX) begin
            emit          = 1'b1;
            run.value     = marker;
            run.count     = {8'd0, in_byte} + 16'd1;
            run.final_run = last_of_stream;
          end else begin
            if (in_byte[7]) run_count_next = {in_byte[6:0], 8'd0};
            else run_count_next = {7'd0, in_byte};
            emit          = last_of_stream;
            run.final_run = 1'b1;
            run.truncated = 1'b1;
          end
        end
        PH_LOW: begin
          run_count_next = run_count | {7'd0, in_byte};
          emit           = last_of_stream;
          run.final_run  = 1'b1;
          run.truncated  = 1'b1;
        end
        PH_VALUE: begin
          emit          = 1'b1;
          run.value     = in_byte;
          run.count     = {1'b0, run_count} + 16'd1;
          run.final_run = last_of_stream;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  `MRD_ASSERT_NEXT(a_last_returns_to_await, in_fire && last_of_stream, phase == PH_AWAIT,
    "phase not idle after end of stream")
  `MRD_ASSERT_SAME(a_trunc_is_final, emit && run.truncated,
    run.final_run && (run.count == 16'd0), "truncated run not a final empty run")

endmodule

@@ rtl/mrd_queue.sv @@
// short run queue between the parser and the output stage
// depends on mrd_pkg and marker_rle_decoder_top_assert.svh
`include "marker_rle_decoder_top_assert.svh"

module mrd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mrd_pkg::run_t   push_data,
  input  logic            pop,
  output mrd_pkg::run_t   pop_data,
  output mrd_pkg::qstat_t stat
);
  import mrd_pkg::*;

  run_t                slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  assign pop_data   = slots[rd_ptr];
  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);

  `MRD_ASSERT_NEXT(a_pop_drains, pop && !push, count + QCNT_W'(1) == $past(count),
    "queue level did not drop after pop")
  `MRD_ASSERT_SAME(a_no_push_when_full, stat.full, !push || pop,
    "push into full queue")

endmodule

@@ rtl/mrd_back.sv @@
// back end: output register that presents runs to the downstream receiver
// depends on mrd_pkg and marker_rle_decoder_top_assert.svh
`include "marker_rle_decoder_top_assert.svh"

module mrd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  mrd_pkg::run_t q_data,
  output logic          q_pop,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [23:0]   m_axis_tdata,   // out_value [7:0], repeat_count [23:8]
  output logic          m_axis_tuser,   // truncated
  output logic          m_axis_tlast
);
  import mrd_pkg::*;

  run_t held;
  logic load;

  assign load  = q_valid && (!m_axis_tvalid || m_axis_tready);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= q_data;
  end

  assign m_axis_tdata = {held.count, held.value};
  assign m_axis_tuser = held.truncated;
  assign m_axis_tlast = held.final_run;

  `MRD_ASSERT_NEXT(a_load_shows_run, load, m_axis_tvalid && (held == $past(q_data)),
    "loaded run not presented")

endmodule

@@ rtl/marker_rle_decoder_top.sv @@
// top level of the marker rle decoder: parser, run queue and output stage
// depends on mrd_pkg, mrd_front, mrd_queue, mrd_back
//
// usage
//   slave channel s_axis_*: one compressed byte per transaction in tdata,
//   tuser marks the marker byte that opens a stream, tlast the final byte.
//   master channel m_axis_*: one run per transaction, tdata carries the
//   byte value and its 16-bit repeat count, tlast marks the last run of a
//   stream and tuser flags a stream that ended inside a marker token.
//   a byte yields zero or one run; a stream's first byte, a token's marker,
//   long descriptor and count bytes yield none unless they end the stream.
// throughput: one byte per cycle sustained; the parser updates its phase on
//   each accepted byte; the four-entry run queue decouples it from the output
//   register, so downstream stalls only back up once the queue is full.
// path: a run enters the run queue as its byte is accepted and moves to the
//   output register when free (parser to queue, queue to output register).
// reset: rst is synchronous; the parser waits for a marker byte, the queue
//   empties and m_axis_tvalid drops. bytes outside a stream are dropped.
// stall: while m_axis_tready is low the output run holds and the queue
//   fills; s_axis_tready falls only when the queue is full.
module marker_rle_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte [7:0]
  input  logic        s_axis_tuser,   // first_of_stream
  input  logic        s_axis_tlast,   // last_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_value [7:0], repeat_count [23:8]
  output logic        m_axis_tuser,   // truncated
  output logic        m_axis_tlast    // final_run
);
  import mrd_pkg::*;

  logic   in_fire;
  logic   emit;
  run_t   front_run;
  run_t   q_head;
  qstat_t q_stat;
  logic   q_pop;

  // input is taken whenever the queue has room
  assign s_axis_tready = !q_stat.full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  mrd_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_fire         (in_fire),
    .in_byte         (s_axis_tdata),
    .first_of_stream (s_axis_tuser),
    .last_of_stream  (s_axis_tlast),
    .emit            (emit),
    .run             (front_run)
  );

  // only accepted bytes that produce a run enter the queue
  mrd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire && emit),
    .push_data (front_run),
    .pop       (q_pop),
    .pop_data  (q_head),
    .stat      (q_stat)
  );

  mrd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (!q_stat.empty),
    .q_data        (q_head),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ bench/mrd_checker.sv @@
// run checker for the marker rle decoder: watches both stream channels,
// predicts each run from the accepted bytes and compares it field by field
// depends on mrd_pkg
`timescale 1ns / 1ps

module mrd_checker
  import mrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte [7:0]
  input  logic        s_axis_tuser,   // first_of_stream
  input  logic        s_axis_tlast,   // last_of_stream
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // out_value [7:0], repeat_count [23:8]
  input  logic        m_axis_tuser,   // truncated
  input  logic        m_axis_tlast,   // final_run
  output int          fail_count,
  output int          pending,
  output int          runs_checked,
  output int          trunc_runs,
  output int          long_runs
);

  phase_t      phase;
  logic [7:0]  esc_byte;
  logic [14:0] len_acc;
  run_t        runs_due[$];
  int          errs;
  int          n_runs;
  int          n_trunc;
  int          n_long;

  function automatic run_t make_run(logic [7:0] v, logic [15:0] n, logic fin, logic tr);
    run_t r;
    r.value     = v;
    r.count     = n;
    r.final_run = fin;
    r.truncated = tr;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errs++;
      $error("%s mismatch: expected %0d actual %0d", name, want, got);
    end
  endfunction

  // advance the parser by one accepted byte, queue the run it produces
  task automatic decode_byte(input logic [7:0] b, input logic first, input logic last);
    if (first) begin
      esc_byte = b;
      len_acc  = '0;
      if (last) begin
        phase = PH_AWAIT;
        runs_due.push_back(make_run(8'h00, 16'd0, 1'b1, 1'b0));
      end else begin
        phase = PH_TOKEN;
      end
      return;
    end
    case (phase)
      PH_TOKEN: begin
        if (b != esc_byte) begin
          runs_due.push_back(make_run(b, 16'd1, last, 1'b0));
          if (last) phase = PH_AWAIT;
          return;
        end
        phase = PH_DESC;
      end
      PH_DESC: begin
        if (b <= SHORT_DESC_MAX) begin
          runs_due.push_back(make_run(esc_byte, {8'h00, b} + 16'd1, last, 1'b0));
          phase = last ? PH_AWAIT : PH_TOKEN;
          return;
        end
        if (b[7]) begin
          len_acc = {b[6:0], 8'h00};
          phase   = PH_LOW;
        end else begin
          len_acc = {7'h00, b};
          phase   = PH_VALUE;
        end
      end
      PH_LOW: begin
        len_acc = {len_acc[14:8], b};
        phase   = PH_VALUE;
      end
      PH_VALUE: begin
        runs_due.push_back(make_run(b, {1'b0, len_acc} + 16'd1, last, 1'b0));
        phase = last ? PH_AWAIT : PH_TOKEN;
        return;
      end
      default: begin
        // stray byte outside a stream
        phase = PH_AWAIT;
        return;
      end
    endcase
    // stream ended in the middle of a token
    if (last) begin
      phase = PH_AWAIT;
      runs_due.push_back(make_run(8'h00, 16'd0, 1'b1, 1'b1));
    end
  endtask

  always @(posedge clk) begin
    run_t want;
    if (rst) begin
      phase    = PH_AWAIT;
      esc_byte = '0;
      len_acc  = '0;
      runs_due.delete();
      errs     = 0;
      n_runs   = 0;
      n_trunc  = 0;
      n_long   = 0;
    end else begin
      // result side first: a run never comes from a byte of the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (runs_due.size() == 0) begin
          errs++;
          $error("run with nothing expected: value %0d count %0d final %0d truncated %0d",
                 m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tlast, m_axis_tuser);
        end else begin
          want = runs_due.pop_front();
          check_field("out_value", 32'(want.value), 32'(m_axis_tdata[7:0]));
          check_field("repeat_count", 32'(want.count), 32'(m_axis_tdata[23:8]));
          check_field("final_run", 32'(want.final_run), 32'(m_axis_tlast));
          check_field("truncated", 32'(want.truncated), 32'(m_axis_tuser));
          n_runs++;
          if (want.truncated) n_trunc++;
          if (want.count > 16'd128) n_long++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        decode_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    end
    fail_count   <= errs;
    pending      <= runs_due.size();
    runs_checked <= n_runs;
    trunc_runs   <= n_trunc;
    long_runs    <= n_long;
  end

endmodule

@@ bench/tb.sv @@
// testbench top for the marker rle decoder: clock, reset, byte stimulus,
// random back-pressure and the verdict
// depends on mrd_pkg, marker_rle_decoder_top and mrd_checker
`timescale 1ns / 1ps

module tb;
  import mrd_pkg::*;

  localparam int TOTAL_BYTES = 1450;     // counted stream bytes, stray ones excluded
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 20;

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // in_byte [7:0]
  logic        s_axis_tuser  = 1'b0;    // first_of_stream
  logic        s_axis_tlast  = 1'b0;    // last_of_stream
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;            // out_value [7:0], repeat_count [23:8]
  logic        m_axis_tuser;            // truncated
  logic        m_axis_tlast;            // final_run

  int fail_count;
  int pending;
  int runs_checked;
  int trunc_runs;
  int long_runs;

  int tx_idle_pct = 0;   // chance in percent that the sender idles a cycle
  int rx_idle_pct = 0;   // chance in percent that the receiver stalls a cycle
  int bytes_sent  = 0;   // counted stream bytes
  int stray_sent  = 0;   // bytes sent while no stream is open
  int streams     = 0;
  bit in_stream   = 1'b0;
  int cycles      = 0;

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  marker_rle_decoder_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  mrd_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .pending       (pending),
    .runs_checked  (runs_checked),
    .trunc_runs    (trunc_runs),
    .long_runs     (long_runs)
  );

  // random receiver stalls, one decision per cycle
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else     m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL marker_rle_decoder_top");
      $finish;
    end
  end

  // one slave transaction, with random idle cycles in front of it;
  // valid stays high between back-to-back bytes
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                           input bit counted);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (counted) bytes_sent++;
    else         stray_sent++;
  endtask

  // hold the sender off until every predicted run has come out
  task automatic wait_runs_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // one stream: marker byte, a random mix of tokens, then a clean end,
  // an end inside a token, or no end at all (the next marker cuts it off)
  task automatic random_stream();
    logic [7:0] esc;
    logic [7:0] v;
    logic [7:0] q[$];
    int         ntok;
    int         ending;
    int         kind;
    int         cut;
    bit         ends;
    esc = 8'($urandom_range(255));
    q.push_back(esc);
    ntok   = ($urandom_range(99) < 6) ? 0 : $urandom_range(1, 12);
    ending = $urandom_range(99);
    for (int k = 0; k < ntok; k++) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        // literal, anything but the marker
        do v = 8'($urandom_range(255)); while (v == esc);
        q.push_back(v);
      end else if (kind < 60) begin
        // short marker run
        q.push_back(esc);
        q.push_back(8'($urandom_range(0, 2)));
      end else if (kind < 80) begin
        // one-byte count, then value
        q.push_back(esc);
        q.push_back(8'($urandom_range(3, 127)));
        q.push_back(8'($urandom_range(255)));
      end else begin
        // two-byte count, then value
        q.push_back(esc);
        q.push_back(8'($urandom_range(128, 255)));
        q.push_back(8'($urandom_range(255)));
        q.push_back(8'($urandom_range(255)));
      end
    end
    // partial token at the tail for truncated streams and some cut-off ones
    if (ending >= 70 && ending < 93) begin
      cut = $urandom_range(0, 3);
      q.push_back(esc);
      if (cut == 1) q.push_back(8'($urandom_range(3, 127)));
      if (cut >= 2) q.push_back(8'($urandom_range(128, 255)));
      if (cut == 3) q.push_back(8'($urandom_range(255)));
    end
    ends = (ending < 85);
    foreach (q[i])
      send_byte(q[i], i == 0, ends && (i == q.size() - 1), 1'b1);
    in_stream = !ends;
    streams++;
  endtask

  initial begin
    int n_stray;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 22;
    rx_idle_pct = 52;

    // directed: stray byte that closes nothing, empty stream
    send_byte(8'hA5, 1'b0, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1, 1'b1);
    // marker 0x00: literal, short runs at both ends, one-byte counts at
    // both ends, two-byte counts from the smallest to 32768
    send_byte(8'h00, 1'b1, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0, 1'b1);
    send_byte(8'h02, 1'b0, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0, 1'b1);
    send_byte(8'h03, 1'b0, 1'b0, 1'b1);
    send_byte(8'hAA, 1'b0, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0, 1'b1);
    send_byte(8'h7F, 1'b0, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0, 1'b1);
    send_byte(8'h80, 1'b0, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0, 1'b1);
    send_byte(8'h55, 1'b0, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1, 1'b1);
    // stream that ends right after a long descriptor
    send_byte(8'h7E, 1'b1, 1'b0, 1'b1);
    send_byte(8'h7E, 1'b0, 1'b0, 1'b1);
    send_byte(8'h85, 1'b0, 1'b1, 1'b1);

    // random part in three idling phases; the sender drains after each
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 22; rx_idle_pct = 52; end
        1: begin tx_idle_pct = 52; rx_idle_pct = 22; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      while (bytes_sent < TOTAL_BYTES * (ph + 1) / 3) begin
        // stray bytes only while no stream is open, so they stay ignored
        if (!in_stream && $urandom_range(99) < 12) begin
          n_stray = $urandom_range(1, 3);
          repeat (n_stray)
            send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), 1'b0);
        end
        random_stream();
      end
      wait_runs_drained();
    end

    // settle: nothing may come out after the last expected run
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d streams, %0d stream bytes and %0d stray bytes", streams,
             bytes_sent, stray_sent);
    $display("checked %0d runs, %0d ended inside a token, %0d longer than 128",
             runs_checked, trunc_runs, long_runs);
    if (fail_count == 0) begin
      $display("PASS marker_rle_decoder_top");
    end else begin
      $display("FAIL marker_rle_decoder_top");
    end
    $finish;
  end

endmodule
